### rtl/aat_pkg.sv
// ----------------------------------------------------------------------------
// aat_pkg
// Shared widths, types, reset values and helpers for the box transform.
// ----------------------------------------------------------------------------
package aat_pkg;

    localparam int COORD_W    = 32;                     // Q16.16 coordinate
    localparam int COEF_W     = 16;                     // Q4.12 coefficient
    localparam int COEF_FRAC  = 12;
    localparam int MUL_W      = COORD_W + COEF_W;       // exact product
    localparam int PROD_W     = MUL_W - COEF_FRAC;      // floored product
    localparam int SUM_W      = PROD_W + 2;             // three products + shift
    localparam int EXT_W      = COORD_W - 1;
    localparam int ROW_W      = 3 * COEF_W;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = ROW_W;
    localparam int IN_TDATA_W  = 6 * COORD_W;
    localparam int OUT_FIELD_W = 9 * COORD_W + 3 * EXT_W;
    localparam int OUT_TDATA_W = ((OUT_FIELD_W + 7) / 8) * 8;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_ROW_X   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ROW_Y   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ROW_Z   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SHIFT_X = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_SHIFT_Y = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_SHIFT_Z = 3'd5;

    // Identity matrix: 1.0 on the diagonal
    localparam logic [ROW_W-1:0] ROW_X_RST = 48'h0000_0000_1000;
    localparam logic [ROW_W-1:0] ROW_Y_RST = 48'h0000_1000_0000;
    localparam logic [ROW_W-1:0] ROW_Z_RST = 48'h1000_0000_0000;

    typedef logic signed [COORD_W-1:0] t_coord;
    typedef logic signed [COEF_W-1:0]  t_coef;
    typedef logic signed [PROD_W-1:0]  t_prod;
    typedef logic signed [SUM_W-1:0]   t_sum;
    typedef logic        [EXT_W-1:0]   t_extent;

    typedef t_coord [2:0]      t_vec3;      // [0] = x in the low bits
    typedef t_coef  [2:0][2:0] t_coef_mat;  // [input axis][output axis]
    typedef t_prod  [2:0][2:0] t_prod_mat;  // [input axis][output axis]

    typedef struct packed {
        t_vec3 hi;
        t_vec3 lo;
    } t_box;

    typedef struct packed {
        t_prod_mat hi;
        t_prod_mat lo;
    } t_prods;

    typedef struct packed {
        t_vec3          ctr;
        t_extent [2:0]  ext;
        t_vec3          hi;
        t_vec3          lo;
    } t_result;

    function automatic t_sum prod_to_sum(input t_prod p);
        return {{(SUM_W - PROD_W){p[PROD_W-1]}}, p};
    endfunction

    function automatic t_sum coord_to_sum(input t_coord c);
        return {{(SUM_W - COORD_W){c[COORD_W-1]}}, c};
    endfunction

    // Clamp a wide sum to the coordinate range
    function automatic t_coord sat_coord(input t_sum v);
        logic hi_same;
        hi_same = (v[SUM_W-1:COORD_W-1] == {(SUM_W - COORD_W + 1){v[SUM_W-1]}});
        if (hi_same)
            return v[COORD_W-1:0];
        else if (v[SUM_W-1])
            return {1'b1, {(COORD_W - 1){1'b0}}};
        else
            return {1'b0, {(COORD_W - 1){1'b1}}};
    endfunction

endpackage

### rtl/aat_mul_stage.sv
// ----------------------------------------------------------------------------
// aat_mul_stage
// Eighteen coordinate by coefficient products, floored by the fraction bits.
// ----------------------------------------------------------------------------
module aat_mul_stage import aat_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_valid,
    output logic      o_ready,
    input  t_box      i_box,
    input  t_coef_mat i_coefs,
    output logic      o_valid,
    input  logic      i_ready,
    output t_prods    o_prods
);

    logic   r_valid;
    t_prods r_prods;
    t_prods n_prods;

    // floor(x * c / 2^COEF_FRAC), exact
    function automatic t_prod mul_scaled(input t_coord x, input t_coef c);
        logic signed [MUL_W-1:0] m;
        m = $signed({{(MUL_W - COORD_W){x[COORD_W-1]}}, x})
          * $signed({{(MUL_W - COEF_W){c[COEF_W-1]}}, c});
        return m[MUL_W-1:COEF_FRAC];
    endfunction

    // not ready while in reset, so no request is taken and then dropped
    assign o_ready = i_rst_n && (!r_valid || i_ready);
    assign o_valid = r_valid;
    assign o_prods = r_prods;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            for (int a = 0; a < 3; a++) begin
                n_prods.lo[i][a] = mul_scaled(i_box.lo[i], i_coefs[i][a]);
                n_prods.hi[i][a] = mul_scaled(i_box.hi[i], i_coefs[i][a]);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_prods <= n_prods;
        end
    end

endmodule

### rtl/aat_bound_stage.sv
// ----------------------------------------------------------------------------
// aat_bound_stage
// Per-axis min and max of the transformed corners, saturated.
// ----------------------------------------------------------------------------
module aat_bound_stage import aat_pkg::*; (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_valid,
    output logic   o_ready,
    input  t_prods i_prods,
    input  t_vec3  i_shift,
    output logic   o_valid,
    input  logic   i_ready,
    output t_box   o_box
);

    logic r_valid;
    t_box r_box;
    t_box n_box;
    t_sum s_lo [3];
    t_sum s_hi [3];

    assign o_ready = !r_valid || i_ready;
    assign o_valid = r_valid;
    assign o_box   = r_box;

    // Each product is monotonic in its coordinate, so the extreme corner
    // picks the smaller / larger product term by term.
    always_comb begin
        for (int a = 0; a < 3; a++) begin
            s_lo[a] = coord_to_sum(i_shift[a]);
            s_hi[a] = coord_to_sum(i_shift[a]);
            for (int i = 0; i < 3; i++) begin
                if (i_prods.lo[i][a] < i_prods.hi[i][a]) begin
                    s_lo[a] = s_lo[a] + prod_to_sum(i_prods.lo[i][a]);
                    s_hi[a] = s_hi[a] + prod_to_sum(i_prods.hi[i][a]);
                end else begin
                    s_lo[a] = s_lo[a] + prod_to_sum(i_prods.hi[i][a]);
                    s_hi[a] = s_hi[a] + prod_to_sum(i_prods.lo[i][a]);
                end
            end
            n_box.lo[a] = sat_coord(s_lo[a]);
            n_box.hi[a] = sat_coord(s_hi[a]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_box <= n_box;
        end
    end

endmodule

### rtl/aat_size_stage.sv
// ----------------------------------------------------------------------------
// aat_size_stage
// Extent and center per axis; this register is the output register.
// ----------------------------------------------------------------------------
module aat_size_stage import aat_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_valid,
    output logic    o_ready,
    input  t_box    i_box,
    output logic    o_valid,
    input  logic    i_ready,
    output t_result o_result
);

    logic                 r_valid;
    t_result              r_result;
    t_result              n_result;
    logic [COORD_W:0]     diff [3];
    logic [COORD_W-1:0]   mid  [3];

    assign o_ready  = !r_valid || i_ready;
    assign o_valid  = r_valid;
    assign o_result = r_result;

    always_comb begin
        for (int a = 0; a < 3; a++) begin
            // hi >= lo always, so the difference is non-negative
            diff[a] = {i_box.hi[a][COORD_W-1], i_box.hi[a]}
                    - {i_box.lo[a][COORD_W-1], i_box.lo[a]};
            // true midpoint always lies in range, so a wrapping add is exact
            mid[a]  = i_box.lo[a] + diff[a][COORD_W:1];
            n_result.lo[a]  = i_box.lo[a];
            n_result.hi[a]  = i_box.hi[a];
            n_result.ext[a] = (diff[a][COORD_W] || diff[a][COORD_W-1]) ?
                              {EXT_W{1'b1}} : diff[a][EXT_W-1:0];
            n_result.ctr[a] = mid[a];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_result <= n_result;
        end
    end

endmodule

### rtl/aabb_affine_transform.sv
// ----------------------------------------------------------------------------
// aabb_affine_transform
// Path: an input request passes the product, bound and size registers in turn
//   before it reaches the output, and is held back only while the output is stalled.
// Throughput: one box per cycle while the output is not stalled; each stage holds one box and the ready chain
//   lets bubbles collapse, so input is taken while a result waits until all
//   three stages hold a box.
// Reset: synchronous, active low; clears stage valids and loads the identity
//   matrix with zero translation. Both input readies are low during reset;
//   the config port is otherwise always ready.
// ----------------------------------------------------------------------------
module aabb_affine_transform import aat_pkg::*; (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    // Config write channel
    input  logic                   i_cfg_valid,
    output logic                   o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [CFG_DATA_W-1:0]  i_cfg_data,
    // Box in
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    // lo_x, lo_y, lo_z, hi_x, hi_y, hi_z (32 bits each, lowest first)
    input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
    // Transformed box out
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    // new_lo_x/y/z, new_hi_x/y/z (32 each), extent_x/y/z (31 each),
    // center_x/y/z (32 each), 3 zero pad bits; lowest first
    output logic [OUT_TDATA_W-1:0] m_axis_tdata
);

    // Config registers
    logic [ROW_W-1:0] r_row_x;
    logic [ROW_W-1:0] r_row_y;
    logic [ROW_W-1:0] r_row_z;
    t_vec3            r_shift;

    t_box      in_box;
    t_coef_mat coefs;

    logic      mul_valid;
    logic      mul_ready;
    t_prods    mul_prods;
    logic      bnd_valid;
    logic      bnd_ready;
    t_box      bnd_box;
    t_result   result;

    assign o_cfg_ready = i_rst_n;

    // The user must write only while idle (the block does not enforce this), so the stages read these directly.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_x <= ROW_X_RST;
            r_row_y <= ROW_Y_RST;
            r_row_z <= ROW_Z_RST;
            r_shift <= '0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                CFG_ROW_X:   r_row_x    <= i_cfg_data;
                CFG_ROW_Y:   r_row_y    <= i_cfg_data;
                CFG_ROW_Z:   r_row_z    <= i_cfg_data;
                CFG_SHIFT_X: r_shift[0] <= i_cfg_data[COORD_W-1:0];
                CFG_SHIFT_Y: r_shift[1] <= i_cfg_data[COORD_W-1:0];
                CFG_SHIFT_Z: r_shift[2] <= i_cfg_data[COORD_W-1:0];
                default: ;  // unknown index: dropped
            endcase
        end
    end

    // Coefficient field a of a row feeds output axis a
    always_comb begin
        for (int a = 0; a < 3; a++) begin
            coefs[0][a] = r_row_x[a*COEF_W +: COEF_W];
            coefs[1][a] = r_row_y[a*COEF_W +: COEF_W];
            coefs[2][a] = r_row_z[a*COEF_W +: COEF_W];
        end
    end

    assign in_box.lo = s_axis_tdata[3*COORD_W-1:0];
    assign in_box.hi = s_axis_tdata[6*COORD_W-1:3*COORD_W];

    aat_mul_stage u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s_axis_tvalid),
        .o_ready (s_axis_tready),
        .i_box   (in_box),
        .i_coefs (coefs),
        .o_valid (mul_valid),
        .i_ready (mul_ready),
        .o_prods (mul_prods)
    );

    aat_bound_stage u_bound (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (mul_valid),
        .o_ready (mul_ready),
        .i_prods (mul_prods),
        .i_shift (r_shift),
        .o_valid (bnd_valid),
        .i_ready (bnd_ready),
        .o_box   (bnd_box)
    );

    aat_size_stage u_size (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (bnd_valid),
        .o_ready  (bnd_ready),
        .i_box    (bnd_box),
        .o_valid  (m_axis_tvalid),
        .i_ready  (m_axis_tready),
        .o_result (result)
    );

    // t_result packs lo, hi, extents, centers from the low bits up
    assign m_axis_tdata = {{(OUT_TDATA_W - OUT_FIELD_W){1'b0}}, result};

endmodule
